FILE: rtl/shda_pkg.sv
// ----------------------------------------------------------------------------
// shda_pkg
// Shared types and constants for the signed decimal/hex string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package shda_pkg;

	// Parser phase codes.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_START  = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_DEC    = 3'd4;
	localparam logic [2:0] PH_HEX    = 3'd5;

	// Character codes that steer the parser.
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	// Parser state carried from one item to the next.
	typedef struct packed {
		logic [2:0]  phase;
		logic        negative;
		logic [31:0] accum;
	} parse_state_t;

	// Result of one parse step.
	typedef struct packed {
		logic        emit;
		logic [31:0] value;
	} step_result_t;

endpackage

`default_nettype wire

FILE: rtl/shda_step.sv
// ----------------------------------------------------------------------------
// shda_step
// Combinational next-state and result logic for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module shda_step (
	input  wire logic [7:0]            ch,
	input  wire logic                  first,
	input  wire shda_pkg::parse_state_t cur,
	output shda_pkg::parse_state_t     nxt,
	output shda_pkg::step_result_t     res
);

	shda_pkg::parse_state_t st;
	logic        is_dec;
	logic        is_lo_hex;
	logic        is_up_hex;
	logic [3:0]  hex_digit;
	logic [31:0] dec_acc;
	logic [31:0] hex_acc;
	logic [31:0] signed_val;

	// Digit classification and the hex digit value.
	always_comb begin
		is_dec    = ch inside {[shda_pkg::CH_ZERO:shda_pkg::CH_NINE]};
		is_lo_hex = ch inside {[shda_pkg::CH_LO_A:shda_pkg::CH_LO_F]};
		is_up_hex = ch inside {[shda_pkg::CH_UP_A:shda_pkg::CH_UP_F]};
		if (is_dec) begin
			hex_digit = ch[3:0];
		end else begin
			// Letters a-f and A-F both carry 1..6 in their low nibble.
			hex_digit = ch[3:0] + 4'd9;
		end
	end

	// A first flag restarts the parse with a cleared state.
	always_comb begin
		if (first) begin
			st = '{phase: shda_pkg::PH_START, negative: 1'b0, accum: 32'd0};
		end else begin
			st = cur;
		end
		dec_acc    = {st.accum[28:0], 3'b000} + {st.accum[30:0], 1'b0}
			+ {28'd0, ch[3:0]};
		hex_acc    = {st.accum[27:0], hex_digit};
		signed_val = st.negative ? (32'd0 - st.accum) : st.accum;
	end

	// Phase transitions; an unmatched character ends a parse and emits.
	always_comb begin
		nxt       = st;
		res.emit  = 1'b0;
		res.value = signed_val;
		case (st.phase)
			shda_pkg::PH_START, shda_pkg::PH_SIGNED, shda_pkg::PH_ZERO,
			shda_pkg::PH_DEC: begin
				if ((st.phase == shda_pkg::PH_START) && (ch == shda_pkg::CH_MINUS)) begin
					nxt.negative = 1'b1;
					nxt.phase    = shda_pkg::PH_SIGNED;
				end else if ((st.phase inside {shda_pkg::PH_START, shda_pkg::PH_SIGNED})
						&& (ch == shda_pkg::CH_ZERO)) begin
					nxt.phase = shda_pkg::PH_ZERO;
				end else if ((st.phase == shda_pkg::PH_ZERO)
						&& (ch inside {shda_pkg::CH_LO_X, shda_pkg::CH_UP_X})) begin
					nxt.phase = shda_pkg::PH_HEX;
				end else if (is_dec) begin
					nxt.accum = dec_acc;
					nxt.phase = shda_pkg::PH_DEC;
				end else begin
					nxt.phase = shda_pkg::PH_IDLE;
					res.emit  = 1'b1;
				end
			end
			shda_pkg::PH_HEX: begin
				if (is_dec || is_lo_hex || is_up_hex) begin
					nxt.accum = hex_acc;
				end else begin
					nxt.phase = shda_pkg::PH_IDLE;
					res.emit  = 1'b1;
				end
			end
			default: begin
				nxt.phase = shda_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/signed_hex_decimal_atoi.sv
// ----------------------------------------------------------------------------
// signed_hex_decimal_atoi
// Streaming parser of signed decimal or 0x-prefixed hex strings to 32 bits.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------
//  in      | in_valid / in_ready  | ch[7:0], first
//  out     | out_valid / out_ready| value[31:0] (signed)
//
// One character item is taken per cycle. An item is held in the input
// register, where the parse step runs and updates the state; an emitted
// value appears in the result register the cycle after. The input stalls
// only while a value waits in the result register and the held item would
// emit another. Reset clears the state to idle and both registers to empty.
`default_nettype none

module signed_hex_decimal_atoi (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         ch,
	input  wire logic               first,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      value
);

	logic                   valid_s1;
	logic [7:0]             ch_s1;
	logic                   first_s1;
	shda_pkg::parse_state_t state_q;
	shda_pkg::parse_state_t state_nxt;
	shda_pkg::step_result_t step_res;
	logic                   consume;
	logic                   in_fire;

	// Parse step on the registered item.
	shda_step u_step (
		.ch    (ch_s1),
		.first (first_s1),
		.cur   (state_q),
		.nxt   (state_nxt),
		.res   (step_res)
	);

	// The held item proceeds unless it emits into an occupied result register that is not being read.
	assign consume  = valid_s1 && (!step_res.emit || !out_valid || out_ready);
	assign in_ready = !valid_s1 || consume;
	assign in_fire  = in_valid && in_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_s1    <= ch;
			first_s1 <= first;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: shda_pkg::PH_IDLE, negative: 1'b0, accum: 32'd0};
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (consume && step_res.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && step_res.emit) begin
			value <= step_res.value;
		end
	end

	// Assertions.
	a_stall_means_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && step_res.emit) |=> out_valid)
		else $error("emitted value did not reach the result register");

	a_first_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && first_s1) |=> ((state_q.phase != shda_pkg::PH_IDLE) || out_valid))
		else $error("first character neither started a parse nor emitted");

endmodule

`default_nettype wire
